### rtl/core/srve_pkg.sv
// Shared types, constants and arithmetic helpers for the radio voice effect core.
`default_nettype none

package srve_pkg;

    // Sample and state formats
    localparam int SAMPLE_W   = 16;
    localparam int STATE_W    = 24;
    localparam int SR_W       = 18;
    localparam int SET_W      = 16;
    localparam int COEF_W     = 18;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BANDWIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WET_MIX     = 3'd4;

    localparam logic [SR_W-1:0]  RST_SAMPLE_RATE = 18'd48000;
    localparam logic [SET_W-1:0] RST_WET_MIX     = 16'd65535;

    // Coefficient derivation
    localparam logic [30:0]       TWO_PI_Q28  = 31'd1686629713;
    localparam logic [27:0]       HP_FREQ_Q16 = 28'd19660800;
    localparam logic [27:0]       LP_BASE_Q16 = 28'd65536000;
    localparam logic [COEF_W-1:0] COEF_CLAMP  = 18'd201770;

    // Fixed gains in Q0.16
    localparam logic [15:0] GAIN_0P9  = 16'd58982;
    localparam logic [15:0] GAIN_0P15 = 16'd9830;
    localparam logic [15:0] GAIN_0P08 = 16'd5243;

    // Noise generator
    localparam logic [31:0] LFSR_TAPS   = 32'h80200003;
    localparam logic [31:0] SEED_LEFT   = 32'h12345678;
    localparam logic [31:0] SEED_RIGHT  = 32'h9E3779B9;

    // Saturation limits
    localparam logic signed [47:0] STATE_MAX = 48'sd8388607;
    localparam logic signed [47:0] STATE_MIN = -48'sd8388608;
    localparam logic signed [47:0] SAMPLE_MAX = 48'sd32767;
    localparam logic signed [47:0] SAMPLE_MIN = -48'sd32768;

    // Tanh table
    localparam int TANH_DEPTH = 256;
    localparam int TIDX_W     = $clog2(TANH_DEPTH);
    localparam int TANH_LAST  = TANH_DEPTH - 1;

    typedef logic [15:0] tanh_tab_t [TANH_DEPTH];

    // Settings handed to each lane
    typedef struct packed {
        logic [COEF_W-1:0] chp;
        logic [COEF_W-1:0] clp;
        logic [SET_W-1:0]  drive;
        logic [SET_W-1:0]  noise_level;
        logic [SET_W-1:0]  wet_mix;
    } lane_cfg_t;

    // Unsigned long division, one quotient bit per pass
    function automatic longint unsigned div_u64(input longint unsigned n,
                                                input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], n[i]};
            if (r >= d)
            begin
                r = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Build tanh(4*i/(DEPTH-1)) by the addition formula in Q2.30
    function automatic tanh_tab_t tanh_build();
        longint unsigned h, h2, h3, h5, h7, th, t, e, num, den;
        tanh_tab_t tab;
        h  = (64'd4 << 30) / 64'(TANH_LAST);
        h2 = (h * h) >> 30;
        h3 = (h2 * h) >> 30;
        h5 = (h3 * h2) >> 30;
        h7 = (h5 * h2) >> 30;
        th = h - h3 / 3 + (64'd2 * h5) / 15 - (64'd17 * h7) / 315;
        t  = 64'd0;
        for (int i = 0; i < TANH_DEPTH; i++) begin
            e = (t * 64'd32768 + (64'd1 << 29)) >> 30;
            tab[i] = (e > 64'd32767) ? 16'd32767 : e[15:0];
            num = t + th;
            den = (64'd1 << 30) + ((t * th) >> 30);
            t = div_u64(num << 30, den);
        end
        return tab;
    endfunction

    localparam tanh_tab_t TANH_TAB = tanh_build();

    // Round half away from zero, shift by 16
    function automatic logic signed [47:0] rshr16(input logic signed [47:0] v);
        logic [47:0] mag;
        logic [47:0] res;
        mag = v[47] ? 48'(-v) : 48'(v);
        res = (mag + 48'd32768) >> 16;
        return v[47] ? -$signed(res) : $signed(res);
    endfunction

    // Round half away from zero, shift by 5
    function automatic logic signed [47:0] rshr5(input logic signed [47:0] v);
        logic [47:0] mag;
        logic [47:0] res;
        mag = v[47] ? 48'(-v) : 48'(v);
        res = (mag + 48'd16) >> 5;
        return v[47] ? -$signed(res) : $signed(res);
    endfunction

    function automatic logic signed [STATE_W-1:0] sat24(input logic signed [47:0] v);
        logic signed [47:0] r;
        r = v;
        if (v > STATE_MAX) r = STATE_MAX;
        if (v < STATE_MIN) r = STATE_MIN;
        return r[STATE_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [47:0] v);
        logic signed [47:0] r;
        r = v;
        if (v > SAMPLE_MAX) r = SAMPLE_MAX;
        if (v < SAMPLE_MIN) r = SAMPLE_MIN;
        return r[SAMPLE_W-1:0];
    endfunction

    // Eight Galois shifts of the noise register
    function automatic logic [31:0] lfsr_step8(input logic [31:0] s);
        logic [31:0] r;
        r = s;
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ LFSR_TAPS) : (r >> 1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/srve_coef.sv
// Filter coefficient unit: derives highpass and lowpass coefficients with a serial divider.
`default_nettype none

module srve_coef (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      restart,
    input  wire logic [srve_pkg::SR_W-1:0] sample_rate,
    input  wire logic [srve_pkg::SET_W-1:0] bandwidth,
    output logic                           busy,
    output logic [srve_pkg::COEF_W-1:0]    chp,
    output logic [srve_pkg::COEF_W-1:0]    clp
);
    import srve_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_LOAD = 3'b010,
        C_DIV  = 3'b100
    } coef_state_t;

    coef_state_t        state_reg;
    logic               pending_reg;
    logic               sel_reg;
    logic               clamp_reg;
    logic [58:0]        rem_reg;
    logic [62:0]        dvs_reg;
    logic [18:0]        q_reg;
    logic [4:0]         cnt_reg;
    logic [COEF_W-1:0]  chp_reg;
    logic [COEF_W-1:0]  clp_reg;

    logic [27:0]        freq;
    logic               ge;
    logic [18:0]        q_next;
    logic [19:0]        q_round;
    logic [COEF_W-1:0]  coef_next;

    // Select the corner frequency and run one divider step
    always_comb
    begin
        freq = sel_reg ? (LP_BASE_Q16 + 28'(bandwidth) * 28'd3000) : HP_FREQ_Q16;
        ge = ({4'b0, rem_reg} >= dvs_reg);
        q_next = {q_reg[17:0], ge};
        q_round = 20'(q_next) + 20'd1;
        coef_next = clamp_reg ? COEF_CLAMP : q_round[COEF_W:1];
    end

    // Sequence the two divisions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= C_IDLE;
            pending_reg <= 1'b1;
            sel_reg     <= 1'b0;
            cnt_reg     <= '0;
            chp_reg     <= '0;
            clp_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                C_IDLE:
                begin
                    if (pending_reg)
                    begin
                        sel_reg   <= 1'b0;
                        state_reg <= C_LOAD;
                    end
                end
                C_LOAD:
                begin
                    cnt_reg   <= 5'd18;
                    state_reg <= C_DIV;
                end
                C_DIV:
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                    begin
                        if (sel_reg)
                        begin
                            clp_reg   <= coef_next;
                            state_reg <= C_IDLE;
                        end
                        else
                        begin
                            chp_reg   <= coef_next;
                            sel_reg   <= 1'b1;
                            state_reg <= C_LOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
            if (restart)
                pending_reg <= 1'b1;
            else if (state_reg == C_IDLE)
                pending_reg <= 1'b0;
        end
    end

    // Hold the dividend, divisor and quotient
    always_ff @(posedge clk)
    begin
        if (state_reg == C_LOAD)
        begin
            rem_reg   <= 59'(freq) * 59'(TWO_PI_Q28);
            clamp_reg <= (sample_rate == '0) ||
                         (41'(freq) * 41'd100 > 41'({sample_rate, 16'b0}) * 41'd49);
            dvs_reg   <= {sample_rate, 45'b0};
            q_reg     <= '0;
        end
        else if (state_reg == C_DIV)
        begin
            if (ge)
                rem_reg <= rem_reg - dvs_reg[58:0];
            q_reg   <= q_next;
            dvs_reg <= dvs_reg >> 1;
        end
    end

    assign busy = pending_reg || (state_reg != C_IDLE);
    assign chp  = chp_reg;
    assign clp  = clp_reg;

endmodule

`default_nettype wire

### rtl/core/srve_lane.sv
// One channel lane: filters, tanh drive, noise and dry/wet blend on a shared multiplier.
`default_nettype none

module srve_lane (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic signed [srve_pkg::SAMPLE_W-1:0] sample_in,
    input  wire logic [31:0]                        seed,
    input  wire srve_pkg::lane_cfg_t                cfg,
    input  wire logic                               take,
    output logic                                    done,
    output logic signed [srve_pkg::SAMPLE_W-1:0]    sample_out
);
    import srve_pkg::*;

    typedef enum logic [20:0] {
        L_IDLE   = 21'b1 << 0,
        L_MUL_HP = 21'b1 << 1,
        L_UPD_HP = 21'b1 << 2,
        L_MUL_LP = 21'b1 << 3,
        L_UPD_LP = 21'b1 << 4,
        L_MUL_G  = 21'b1 << 5,
        L_UPD_G  = 21'b1 << 6,
        L_MUL_T  = 21'b1 << 7,
        L_UPD_T  = 21'b1 << 8,
        L_MUL_K  = 21'b1 << 9,
        L_UPD_K  = 21'b1 << 10,
        L_MUL_NS = 21'b1 << 11,
        L_UPD_NS = 21'b1 << 12,
        L_MUL_NL = 21'b1 << 13,
        L_UPD_NL = 21'b1 << 14,
        L_MUL_N2 = 21'b1 << 15,
        L_UPD_N2 = 21'b1 << 16,
        L_MUL_D  = 21'b1 << 17,
        L_MUL_W  = 21'b1 << 18,
        L_UPD_M  = 21'b1 << 19,
        L_DONE   = 21'b1 << 20
    } lane_state_t;

    lane_state_t                state_reg;
    lane_state_t                state_next;
    logic signed [STATE_W-1:0]  hp_st_reg;
    logic signed [STATE_W-1:0]  lp_st_reg;
    logic signed [STATE_W-1:0]  ns_st_reg;
    logic [31:0]                lfsr_reg;

    logic signed [20:0]         x_reg;
    logic signed [STATE_W-1:0]  v_reg;
    logic signed [STATE_W-1:0]  dist_reg;
    logic signed [46:0]         p_reg;
    logic signed [46:0]         acc_reg;
    logic                       neg_reg;
    logic [9:0]                 idx_reg;
    logic [15:0]                fr_reg;
    logic [15:0]                t0_reg;
    logic [15:0]                t_reg;
    logic signed [SAMPLE_W-1:0] out_reg;

    logic signed [25:0]         mul_a;
    logic signed [20:0]         mul_b;
    logic signed [47:0]         p_rnd;
    logic signed [STATE_W-1:0]  hp_new;
    logic signed [STATE_W-1:0]  lp_new;
    logic signed [STATE_W-1:0]  y;
    logic [24:0]                ax_wide;
    logic [31:0]                pos;
    logic                       clip;
    logic [15:0]                t0;
    logic [15:0]                t1;
    logic [31:0]                k_sum;
    logic signed [STATE_W-1:0]  r_mag;
    logic signed [STATE_W-1:0]  w;
    logic signed [47:0]         mixed;

    // Shared arithmetic for the current step
    always_comb
    begin
        p_rnd   = rshr16(48'(p_reg));
        hp_new  = sat24(48'(hp_st_reg) + p_rnd);
        lp_new  = sat24(48'(lp_st_reg) + p_rnd);
        y       = sat24(p_rnd);
        ax_wide = y[STATE_W-1] ? -25'(y) : 25'(y);
        pos     = {ax_wide[23:0], 8'b0} - 32'(ax_wide[23:0]);
        clip    = (idx_reg >= 10'(TANH_LAST));
        t0      = clip ? TANH_TAB[TANH_LAST] : TANH_TAB[idx_reg[TIDX_W-1:0]];
        t1      = clip ? t0 : TANH_TAB[TIDX_W'(idx_reg[TIDX_W-1:0] + 1'b1)];
        k_sum   = p_reg[31:0] + 32'd32768;
        r_mag   = STATE_W'({k_sum[31:16], 5'b0});
        w       = {{3{lfsr_reg[15]}}, lfsr_reg[15:0], 5'b0};
        mixed   = rshr16(48'(acc_reg) + 48'(p_reg));
    end

    // Pick the multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            L_MUL_HP:
            begin
                mul_a = 26'(25'(x_reg) - 25'(hp_st_reg));
                mul_b = $signed({3'b0, cfg.chp});
            end
            L_MUL_LP:
            begin
                mul_a = 26'(25'(v_reg) - 25'(lp_st_reg));
                mul_b = $signed({3'b0, cfg.clp});
            end
            L_MUL_G:
            begin
                mul_a = 26'(v_reg);
                mul_b = $signed(21'(20'd65536 + {cfg.drive, 3'b0}));
            end
            L_MUL_T:
            begin
                mul_a = $signed({10'b0, fr_reg});
                mul_b = $signed({5'b0, 16'(t1 - t0)});
            end
            L_MUL_K:
            begin
                mul_a = $signed({10'b0, t_reg});
                mul_b = $signed({5'b0, GAIN_0P9});
            end
            L_MUL_NS:
            begin
                mul_a = 26'(25'(w) - 25'(ns_st_reg));
                mul_b = $signed({5'b0, GAIN_0P15});
            end
            L_MUL_NL:
            begin
                mul_a = 26'(ns_st_reg);
                mul_b = $signed({5'b0, cfg.noise_level});
            end
            L_MUL_N2:
            begin
                mul_a = 26'(v_reg);
                mul_b = $signed({5'b0, GAIN_0P08});
            end
            L_MUL_D:
            begin
                mul_a = 26'(x_reg);
                mul_b = $signed({4'b0, 17'(17'h10000 - 17'(cfg.wet_mix))});
            end
            L_MUL_W:
            begin
                mul_a = 26'(v_reg);
                mul_b = $signed({5'b0, cfg.wet_mix});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Advance through the steps of one sample
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            L_IDLE:   if (start) state_next = L_MUL_HP;
            L_MUL_HP: state_next = L_UPD_HP;
            L_UPD_HP: state_next = L_MUL_LP;
            L_MUL_LP: state_next = L_UPD_LP;
            L_UPD_LP: state_next = L_MUL_G;
            L_MUL_G:  state_next = L_UPD_G;
            L_UPD_G:  state_next = L_MUL_T;
            L_MUL_T:  state_next = L_UPD_T;
            L_UPD_T:  state_next = L_MUL_K;
            L_MUL_K:  state_next = L_UPD_K;
            L_UPD_K:  state_next = L_MUL_NS;
            L_MUL_NS: state_next = L_UPD_NS;
            L_UPD_NS: state_next = L_MUL_NL;
            L_MUL_NL: state_next = L_UPD_NL;
            L_UPD_NL: state_next = L_MUL_N2;
            L_MUL_N2: state_next = L_UPD_N2;
            L_UPD_N2: state_next = L_MUL_D;
            L_MUL_D:  state_next = L_MUL_W;
            L_MUL_W:  state_next = L_UPD_M;
            L_UPD_M:  state_next = L_DONE;
            L_DONE:   if (take) state_next = L_IDLE;
            default:  state_next = L_IDLE;
        endcase
    end

    // Hold the channel state across samples
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            hp_st_reg <= '0;
            lp_st_reg <= '0;
            ns_st_reg <= '0;
            lfsr_reg  <= seed;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == L_MUL_HP || state_reg == L_UPD_HP)
                lfsr_reg <= lfsr_step8(lfsr_reg);
            if (state_reg == L_UPD_HP)
                hp_st_reg <= hp_new;
            if (state_reg == L_UPD_LP)
                lp_st_reg <= lp_new;
            if (state_reg == L_UPD_NS)
                ns_st_reg <= sat24(48'(ns_st_reg) + p_rnd);
        end
    end

    // Working registers of the current sample
    always_ff @(posedge clk)
    begin
        p_reg <= 47'(mul_a * mul_b);
        if (state_reg == L_IDLE && start)
            x_reg <= {sample_in, 5'b0};
        if (state_reg == L_UPD_HP)
            v_reg <= sat24(48'(x_reg) - 48'(hp_new));
        if (state_reg == L_UPD_LP)
            v_reg <= lp_new;
        if (state_reg == L_UPD_G)
        begin
            neg_reg <= y[STATE_W-1];
            idx_reg <= pos[31:22];
            fr_reg  <= pos[21:6];
        end
        if (state_reg == L_MUL_T)
            t0_reg <= t0;
        if (state_reg == L_UPD_T)
            t_reg <= t0_reg + p_reg[31:16];
        if (state_reg == L_UPD_K)
            dist_reg <= neg_reg ? -r_mag : r_mag;
        if (state_reg == L_UPD_NL)
            v_reg <= STATE_W'(p_rnd);
        if (state_reg == L_UPD_N2)
            v_reg <= sat24(48'(dist_reg) + p_rnd);
        if (state_reg == L_MUL_W)
            acc_reg <= p_reg;
        if (state_reg == L_UPD_M)
            out_reg <= sat16(rshr5(mixed));
    end

    assign done       = (state_reg == L_DONE);
    assign sample_out = out_reg;

endmodule

`default_nettype wire

### rtl/core/stereo_radio_voice_effect_core.sv
// Top level of the stereo radio voice effect: registers, coefficient unit, two lanes, output merge.
//
//  channel | handshake                | payload
//  --------+--------------------------+----------------------------------
//  input   | in_valid / in_stall      | left_in, right_in (Q1.15)
//  output  | out_valid / out_stall    | left_out, right_out (Q1.15)
//  config  | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// Each request steps through the lane states from acceptance to a loaded output register; both
// channels run side by side in their lanes, each stepping its shared multiplier.
// After reset and after each write of sample_rate or bandwidth the coefficient
// divider runs, and in_stall stays high meanwhile.
// A new request is taken once the previous result has moved to the output register,
// even while out_stall holds that result.
`default_nettype none

module stereo_radio_voice_effect_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [srve_pkg::SAMPLE_W-1:0] left_in,
    input  wire logic signed [srve_pkg::SAMPLE_W-1:0] right_in,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [srve_pkg::SAMPLE_W-1:0]      left_out,
    output logic signed [srve_pkg::SAMPLE_W-1:0]      right_out,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [srve_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [srve_pkg::SR_W-1:0]            cfg_data
);
    import srve_pkg::*;

    logic [SR_W-1:0]            sample_rate_reg;
    logic [SET_W-1:0]           bandwidth_reg;
    logic [SET_W-1:0]           noise_level_reg;
    logic [SET_W-1:0]           drive_reg;
    logic [SET_W-1:0]           wet_mix_reg;
    logic                       busy_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] left_reg;
    logic signed [SAMPLE_W-1:0] right_reg;

    logic                       cfg_wr;
    logic                       coef_restart;
    logic                       coef_busy;
    logic [COEF_W-1:0]          chp;
    logic [COEF_W-1:0]          clp;
    lane_cfg_t                  lane_cfg;
    logic                       accept;
    logic                       left_done;
    logic                       right_done;
    logic signed [SAMPLE_W-1:0] left_res;
    logic signed [SAMPLE_W-1:0] right_res;
    logic                       merge;

    assign cfg_ready    = 1'b1;
    assign cfg_wr       = cfg_valid && cfg_ready;
    assign coef_restart = cfg_wr &&
                          (cfg_index == REG_SAMPLE_RATE || cfg_index == REG_BANDWIDTH);

    // Store configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg <= RST_SAMPLE_RATE;
            bandwidth_reg   <= '0;
            noise_level_reg <= '0;
            drive_reg       <= '0;
            wet_mix_reg     <= RST_WET_MIX;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_SAMPLE_RATE: sample_rate_reg <= cfg_data;
                REG_BANDWIDTH:   bandwidth_reg   <= cfg_data[SET_W-1:0];
                REG_NOISE_LEVEL: noise_level_reg <= cfg_data[SET_W-1:0];
                REG_DRIVE:       drive_reg       <= cfg_data[SET_W-1:0];
                REG_WET_MIX:     wet_mix_reg     <= cfg_data[SET_W-1:0];
                default:         ;
            endcase
        end
    end

    srve_coef u_coef (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (coef_restart),
        .sample_rate (sample_rate_reg),
        .bandwidth   (bandwidth_reg),
        .busy        (coef_busy),
        .chp         (chp),
        .clp         (clp)
    );

    always_comb
    begin
        lane_cfg.chp         = chp;
        lane_cfg.clp         = clp;
        lane_cfg.drive       = drive_reg;
        lane_cfg.noise_level = noise_level_reg;
        lane_cfg.wet_mix     = wet_mix_reg;
    end

    assign in_stall = coef_busy || busy_reg;
    assign accept   = in_valid && !in_stall;

    srve_lane u_lane_left (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .sample_in  (left_in),
        .seed       (SEED_LEFT),
        .cfg        (lane_cfg),
        .take       (merge),
        .done       (left_done),
        .sample_out (left_res)
    );

    srve_lane u_lane_right (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .sample_in  (right_in),
        .seed       (SEED_RIGHT),
        .cfg        (lane_cfg),
        .take       (merge),
        .done       (right_done),
        .sample_out (right_res)
    );

    // Merge both lanes into the output register once it is free
    assign merge = left_done && right_done && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                busy_reg <= 1'b1;
            else if (merge)
                busy_reg <= 1'b0;
            if (merge)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (merge)
        begin
            left_reg  <= left_res;
            right_reg <= right_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_reg;
    assign right_out = right_reg;

endmodule

`default_nettype wire
